// File: design/file_transfer_receiver_fsm_assert.svh
// Assertion macros used by the file transfer receiver engine.
`ifndef FILE_TRANSFER_RECEIVER_FSM_ASSERT_SVH
`define FILE_TRANSFER_RECEIVER_FSM_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FTR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ftr assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FTR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ftr assertion failed");

`endif

// File: design/ftr_pkg.sv
// Types and constants of the file transfer receiver.
package ftr_pkg;

  // Message framing
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned DATA_SHIFT   = 10;
  localparam int unsigned DATA_BYTES   = 1 << DATA_SHIFT;
  localparam int unsigned NTF_BYTES    = 4;
  localparam int unsigned INFO_BYTES   = 12;
  localparam int unsigned GAP_RESET    = 100;

  localparam logic [15:0] DATA_LEN = 16'(DATA_BYTES);
  localparam logic [15:0] NTF_LEN  = 16'(NTF_BYTES);
  localparam logic [15:0] INFO_LEN = 16'(INFO_BYTES);

  // Incoming message kinds; code 7 is unused
  typedef enum logic [2:0] {
    MSG_NTF     = 3'd0,
    MSG_INFO    = 3'd1,
    MSG_DATA    = 3'd2,
    MSG_FIN     = 3'd3,
    MSG_CXL     = 3'd4,
    MSG_UNKNOWN = 3'd5,
    MSG_TIMEOUT = 3'd6
  } msg_kind_t;

  // Transfer phases
  typedef enum logic [2:0] {
    PH_CHK  = 3'd0,
    PH_RDY  = 3'd1,
    PH_DATA = 3'd2,
    PH_DONE = 3'd3,
    PH_FIN  = 3'd4,
    PH_CXL  = 3'd5
  } phase_t;

  // Reply codes
  typedef enum logic [2:0] {
    RK_NONE = 3'd0,
    RK_CHK  = 3'd1,
    RK_RDY  = 3'd2,
    RK_RTX  = 3'd3,
    RK_DONE = 3'd4,
    RK_CXL  = 3'd5
  } reply_kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CUR_VERSION = 2'd0,
    CFG_PACKET_GAP  = 2'd1,
    CFG_MAGIC       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] current_version;
    logic [31:0] packet_gap_us;
    logic [31:0] magic_value;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        crc_ok;
    logic [31:0] magic;
    logic [15:0] msg_bytes;
    logic [15:0] hdr_payload_len;
    logic [31:0] total_packets;
    logic [31:0] seq_num;
    logic [31:0] offered_version;
    logic [31:0] offered_length;
    logic [31:0] offered_crc;
    logic [31:0] stored_file_crc;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  reply_kind;
    logic [31:0] reply_version;
    logic [31:0] reply_length;
    logic [31:0] reply_crc;
    logic [31:0] reply_gap;
    logic [31:0] reply_psn;
    logic        store_payload;
    logic [15:0] store_bytes;
    logic        discard_file;
    logic        file_done;
    logic        busy_res;
  } out_item_t;

endpackage

// File: design/ftr_cfg_regs.sv
// Configuration register bank of the file transfer receiver.
module ftr_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [31:0]         cfg_wdata,
  output ftr_pkg::cfg_t       cfg
);

  ftr_pkg::cfg_t cfg_r;
  ftr_pkg::cfg_t cfg_nxt;

  // Decode the register index; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (ftr_pkg::cfg_idx_t'(cfg_idx))
        ftr_pkg::CFG_CUR_VERSION: cfg_nxt.current_version = cfg_wdata;
        ftr_pkg::CFG_PACKET_GAP:  cfg_nxt.packet_gap_us   = cfg_wdata;
        ftr_pkg::CFG_MAGIC:       cfg_nxt.magic_value     = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_version <= '0;
      cfg_r.packet_gap_us   <= 32'(ftr_pkg::GAP_RESET);
      cfg_r.magic_value     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/ftr_engine.sv
// Transfer state machine: integrity check, phase tracking and reply build.
module ftr_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  ftr_pkg::in_item_t    item,
  input  ftr_pkg::cfg_t        cfg,
  output ftr_pkg::out_item_t   result
);

  // Action chosen for one transaction
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CHK,
    ACT_RDY,
    ACT_RTX,
    ACT_STORE,
    ACT_DONE,
    ACT_STORE_CXL,
    ACT_FIN,
    ACT_CXL,
    ACT_CXL_DISCARD
  } act_t;

  logic             active_r, active_nxt;
  ftr_pkg::phase_t  phase_r, phase_nxt;
  logic [31:0]      new_version_r, new_version_nxt;
  logic [31:0]      file_len_r, file_len_nxt;
  logic [31:0]      file_crc_r, file_crc_nxt;
  logic [31:0]      packet_count_r, packet_count_nxt;
  logic [31:0]      next_psn_r, next_psn_nxt;
  logic [31:0]      bytes_stored_r, bytes_stored_nxt;

  ftr_pkg::msg_kind_t kind;
  logic             start;
  logic [31:0]      new_version_c, file_len_c, file_crc_c;
  logic [31:0]      packet_count_c, next_psn_c, bytes_stored_c;
  logic             intact;
  logic [15:0]      pl;
  logic             is_first, is_mid;
  logic [15:0]      last_rem, want;
  logic             data_phase_ok;
  logic [31:0]      bs_sum, np_inc, pkt_cnt_info;
  act_t             act, act_h;
  logic             fin_seen, cxl_seen, rtx_seen, idle_other, idle_quiet;

  // A starting NTF sees a cleared transfer context
  always_comb begin
    kind           = ftr_pkg::msg_kind_t'(item.kind);
    start          = !active_r && (kind == ftr_pkg::MSG_NTF);
    new_version_c  = start ? '0 : new_version_r;
    file_len_c     = start ? '0 : file_len_r;
    file_crc_c     = start ? '0 : file_crc_r;
    packet_count_c = start ? '0 : packet_count_r;
    next_psn_c     = start ? '0 : next_psn_r;
    bytes_stored_c = start ? '0 : bytes_stored_r;
  end

  // Integrity and length checks
  always_comb begin
    intact = item.crc_ok
          && (item.magic == cfg.magic_value)
          && ({1'b0, item.msg_bytes} ==
              ({1'b0, item.hdr_payload_len} + 17'(ftr_pkg::HEADER_BYTES)))
          && (item.total_packets > item.seq_num);
    pl       = item.hdr_payload_len;
    is_first = (item.seq_num == '0);
    is_mid   = (item.seq_num < (item.total_packets - 32'd1));
    last_rem = 16'(file_len_c[ftr_pkg::DATA_SHIFT-1:0]);
    if (is_first || is_mid) begin
      want = ftr_pkg::DATA_LEN;
    end else if (last_rem == '0) begin
      want = ftr_pkg::DATA_LEN;
    end else begin
      want = last_rem;
    end
    data_phase_ok = is_first ? (phase_r == ftr_pkg::PH_RDY) : (phase_r == ftr_pkg::PH_DATA);
    bs_sum        = bytes_stored_c + 32'(pl);
    np_inc        = next_psn_c + 32'd1;
    // ceil(length / DATA_BYTES) as a shift
    pkt_cnt_info  = 32'((33'(item.offered_length) + 33'(ftr_pkg::DATA_BYTES - 1))
                        >> ftr_pkg::DATA_SHIFT);
  end

  // Message dispatch
  always_comb begin
    act_h = ACT_NONE;
    if (intact) begin
      case (kind)
        ftr_pkg::MSG_NTF: begin
          act_h = (pl == ftr_pkg::NTF_LEN) ? ACT_CHK : ACT_CXL;
        end
        ftr_pkg::MSG_INFO: begin
          if ((phase_r == ftr_pkg::PH_CHK) && (pl == ftr_pkg::INFO_LEN)
              && (new_version_c == item.offered_version) && (item.offered_length != '0)) begin
            act_h = ACT_RDY;
          end else begin
            act_h = ACT_CXL;
          end
        end
        ftr_pkg::MSG_DATA: begin
          if (!data_phase_ok || (pl != want)) begin
            act_h = ACT_CXL;
          end else if (item.seq_num != next_psn_c) begin
            act_h = ACT_RTX;
          end else if (np_inc == packet_count_c) begin
            if ((bs_sum != file_len_c) || (file_crc_c != item.stored_file_crc)) begin
              act_h = ACT_STORE_CXL;
            end else begin
              act_h = ACT_DONE;
            end
          end else begin
            act_h = ACT_STORE;
          end
        end
        ftr_pkg::MSG_FIN: begin
          act_h = ((phase_r == ftr_pkg::PH_DONE) && (pl == '0)) ? ACT_FIN : ACT_CXL;
        end
        ftr_pkg::MSG_CXL: begin
          if ((phase_r == ftr_pkg::PH_RDY) || (phase_r == ftr_pkg::PH_DATA)) begin
            act_h = ACT_CXL_DISCARD;
          end else begin
            act_h = ACT_CXL;
          end
        end
        default: act_h = ACT_NONE;
      endcase
    end

    // Idle ignores all but NTF; a timeout while active cancels unchecked
    if (!active_r) begin
      act = start ? act_h : ACT_NONE;
    end else if (kind == ftr_pkg::MSG_TIMEOUT) begin
      act = ACT_CXL;
    end else begin
      act = act_h;
    end
  end

  // Next state
  always_comb begin
    active_nxt       = active_r || start;
    phase_nxt        = phase_r;
    new_version_nxt  = new_version_c;
    file_len_nxt     = file_len_c;
    file_crc_nxt     = file_crc_c;
    packet_count_nxt = packet_count_c;
    next_psn_nxt     = next_psn_c;
    bytes_stored_nxt = bytes_stored_c;
    case (act)
      ACT_CHK: begin
        new_version_nxt = item.offered_version;
        phase_nxt       = ftr_pkg::PH_CHK;
      end
      ACT_RDY: begin
        file_len_nxt     = item.offered_length;
        file_crc_nxt     = item.offered_crc;
        packet_count_nxt = pkt_cnt_info;
        bytes_stored_nxt = '0;
        phase_nxt        = ftr_pkg::PH_RDY;
      end
      ACT_STORE: begin
        bytes_stored_nxt = bs_sum;
        next_psn_nxt     = np_inc;
        phase_nxt        = ftr_pkg::PH_DATA;
      end
      ACT_DONE: begin
        bytes_stored_nxt = bs_sum;
        next_psn_nxt     = np_inc;
        phase_nxt        = ftr_pkg::PH_DONE;
      end
      ACT_STORE_CXL: begin
        bytes_stored_nxt = bs_sum;
        next_psn_nxt     = np_inc;
        phase_nxt        = ftr_pkg::PH_CXL;
        active_nxt       = 1'b0;
      end
      ACT_FIN: begin
        phase_nxt  = ftr_pkg::PH_FIN;
        active_nxt = 1'b0;
      end
      ACT_CXL, ACT_CXL_DISCARD: begin
        phase_nxt  = ftr_pkg::PH_CXL;
        active_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // Result fields; anything not used by the reply stays zero
  always_comb begin
    result          = '0;
    result.busy_res = active_nxt;
    case (act)
      ACT_CHK: begin
        result.reply_kind    = ftr_pkg::RK_CHK;
        result.reply_version = cfg.current_version;
      end
      ACT_RDY: begin
        result.reply_kind    = ftr_pkg::RK_RDY;
        result.reply_version = new_version_c;
        result.reply_length  = item.offered_length;
        result.reply_gap     = cfg.packet_gap_us;
      end
      ACT_RTX: begin
        result.reply_kind = ftr_pkg::RK_RTX;
        result.reply_psn  = next_psn_c;
      end
      ACT_STORE: begin
        result.store_payload = 1'b1;
        result.store_bytes   = pl;
      end
      ACT_DONE: begin
        result.reply_kind    = ftr_pkg::RK_DONE;
        result.reply_version = new_version_c;
        result.reply_length  = file_len_c;
        result.reply_crc     = file_crc_c;
        result.store_payload = 1'b1;
        result.store_bytes   = pl;
      end
      ACT_STORE_CXL: begin
        result.reply_kind    = ftr_pkg::RK_CXL;
        result.store_payload = 1'b1;
        result.store_bytes   = pl;
      end
      ACT_FIN: begin
        result.file_done = 1'b1;
      end
      ACT_CXL: begin
        result.reply_kind = ftr_pkg::RK_CXL;
      end
      ACT_CXL_DISCARD: begin
        result.reply_kind   = ftr_pkg::RK_CXL;
        result.discard_file = 1'b1;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r       <= 1'b0;
      phase_r        <= ftr_pkg::PH_FIN;
      new_version_r  <= '0;
      file_len_r     <= '0;
      file_crc_r     <= '0;
      packet_count_r <= '0;
      next_psn_r     <= '0;
      bytes_stored_r <= '0;
    end else if (step_en) begin
      active_r       <= active_nxt;
      phase_r        <= phase_nxt;
      new_version_r  <= new_version_nxt;
      file_len_r     <= file_len_nxt;
      file_crc_r     <= file_crc_nxt;
      packet_count_r <= packet_count_nxt;
      next_psn_r     <= next_psn_nxt;
      bytes_stored_r <= bytes_stored_nxt;
    end
  end

  // Conditions watched by the checks below
  assign fin_seen   = step_en && result.file_done;
  assign cxl_seen   = step_en && (result.reply_kind == ftr_pkg::RK_CXL);
  assign rtx_seen   = step_en && (result.reply_kind == ftr_pkg::RK_RTX);
  assign idle_other = step_en && !active_r && (item.kind != ftr_pkg::MSG_NTF);
  assign idle_quiet = (result.reply_kind == ftr_pkg::RK_NONE) && !result.busy_res
                   && !result.store_payload;

`include "file_transfer_receiver_fsm_assert.svh"

  // A completed transfer closes the transaction in phase FIN
  `FTR_ASSERT_NXT(a_fin_closes, clk, rst_n, fin_seen, !active_r && (phase_r == ftr_pkg::PH_FIN))
  // Any CXL reply leaves the block idle in phase CXL
  `FTR_ASSERT_NXT(a_cxl_closes, clk, rst_n, cxl_seen, !active_r && (phase_r == ftr_pkg::PH_CXL))
  // A retransmit request changes none of the transfer counters
  `FTR_ASSERT_NXT(a_rtx_holds, clk, rst_n, rtx_seen, $stable({next_psn_r, bytes_stored_r, phase_r}))
  // While idle, only an NTF produces anything
  `FTR_ASSERT_IMP(a_idle_quiet, clk, rst_n, idle_other, idle_quiet)

endmodule

// File: design/file_transfer_receiver_fsm.sv
// Top level of the file transfer receiver: handshakes, input and result registers.
//
// One decoded message header (or a receive timeout) goes in per transaction and exactly one
// result comes out. The block takes a new transaction every clock cycle while the result side
// keeps up; an accepted transaction is held in the input register, then passes the
// integrity/phase logic into the result register, where the result waits until taken. The
// rate of one transaction per cycle holds while the result register drains; it is set by the
// single pass of compare logic between those two registers, which also updates the transfer
// state so the next transaction sees it. Configuration writes take effect at the next edge and
// are meant to be issued only while no transaction is in flight.
module file_transfer_receiver_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ftr_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ftr_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [31:0]         cfg_wdata
);

  ftr_pkg::cfg_t      cfg;
  ftr_pkg::in_item_t  in_item_r;
  logic               in_vld_r;
  ftr_pkg::out_item_t out_item_r;
  logic               out_vld_r;
  ftr_pkg::out_item_t result;
  logic               advance;
  logic               step_en;

  ftr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Pipeline moves when the result register is empty or being drained
  assign advance  = !out_vld_r || out_ready;
  assign step_en  = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  ftr_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule
